[rtl/bfpa_pkg.sv]
// Package for the best-fit pool allocator: payload structs, status codes,
// pool constants and the segment entry type. No dependencies.
package bfpa_pkg;

   localparam int POOL_BLOCKS_DEF  = 32;
   localparam int BLOCK_BYTES_DEF  = 128;
   localparam int HEADER_BYTES_DEF = 12;
   localparam int MAX_SEGMENTS_DEF = 256;

   localparam int SIZE_W = 13;
   localparam int ADDR_W = 12;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ALLOC_ERR = 2'd1,
      ST_BAD_FREE  = 2'd2
   } status_type;

   typedef struct packed {
      logic              operation;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] payload_offset;
      logic [SIZE_W-1:0] used_bytes;
      logic [SIZE_W-1:0] peak_bytes;
      logic [SIZE_W-1:0] pool_total;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic              free;
   } seg_type;

endpackage

[rtl/best_fit_pool_allocator.sv]
// Best-fit pool allocator top level: sequencer walking the segment table.
// Allocate scans every entry for the best fit, and a split shifts the entries
// above it up; free scans to find the entry, then runs a merge pass that shifts
// entries down. One transaction at a time.
// Reset: one segment covering the pool, counters cleared; no clearing pass.
// Depends on bfpa_pkg and bfpa_seg_mem.
module best_fit_pool_allocator #(
   parameter int POOL_BLOCKS  = bfpa_pkg::POOL_BLOCKS_DEF,
   parameter int BLOCK_BYTES  = bfpa_pkg::BLOCK_BYTES_DEF,
   parameter int HEADER_BYTES = bfpa_pkg::HEADER_BYTES_DEF,
   parameter int MAX_SEGMENTS = bfpa_pkg::MAX_SEGMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfpa_pkg::rsp_type rsp_data
);
   import bfpa_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = AW + 1;
   localparam int POOL_BYTES = POOL_BLOCKS * BLOCK_BYTES;
   localparam int SEG0_SIZE = (POOL_BYTES >= HEADER_BYTES) ? POOL_BYTES - HEADER_BYTES : 0;
   localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
   localparam logic [CW-1:0] ONE = CW'(1);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_SRD   = 11'b00000000010,
      S_SCHK  = 11'b00000000100,
      S_ADEC  = 11'b00000001000,
      S_URD   = 11'b00000010000,
      S_UWR   = 11'b00000100000,
      S_AFIN  = 11'b00001000000,
      S_MRD   = 11'b00010000000,
      S_MCHK  = 11'b00100000000,
      S_DRD   = 11'b01000000000,
      S_DWR   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] best_ff, best_in;
   logic [SIZE_W-1:0] diff_ff, diff_in;
   logic found_ff, found_in;
   logic [SIZE_W-1:0] used_ff, used_in, peak_ff, peak_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   seg_type hold_ff, hold_in;   // best entry / merge left entry
   req_type req_ff, req_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   logic seg0_ok_ff, seg0_ok_in; // entry 0 not yet written: reads as reset entry

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   seg_type wr_data, rd_raw, rd;
   logic [CW-1:0] rd_idx;
   logic rd_was0_ff;

   bfpa_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );

   always_comb begin
      rd = rd_raw;
      if (!seg0_ok_ff && rd_was0_ff) begin
         rd.start = '0;
         rd.size  = SIZE_W'(SEG0_SIZE);
         rd.free  = 1'b1;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   logic [SIZE_W:0] rsize;
   logic [SIZE_W-1:0] cdiff;
   logic [SIZE_W:0] payoff;
   assign rsize = ({1'b0, req_ff.request_size} + (SIZE_W+1)'(7)) & ~(SIZE_W+1)'(7);
   assign cdiff = rd.size - rsize[SIZE_W-1:0];
   assign payoff = {1'b0, rd.start} + (SIZE_W+1)'(HEADER_BYTES);

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; best_in = best_ff;
      diff_in = diff_ff; found_in = found_ff; used_in = used_ff; peak_in = peak_ff;
      size_in = size_ff; hold_in = hold_ff; req_in = req_ff; rv_in = rv_ff;
      rsp_in = rsp_ff; seg0_ok_in = seg0_ok_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = hold_ff; rd_idx = idx_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      rsp_in.pool_total = SIZE_W'(POOL_BYTES);

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data; idx_in = '0; found_in = 1'b0; rd_idx = '0;
               state_in = S_SRD;
            end
         end
         S_SRD: begin // read issued for idx_ff
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (req_ff.operation == OP_ALLOC) begin
               if (rd.free && {1'b0, rd.size} >= rsize && (!found_ff || cdiff < diff_ff)) begin
                  found_in = 1'b1; best_in = idx_ff; diff_in = cdiff; hold_in = rd;
               end
            end else if (!found_ff && payoff[SIZE_W-1:0] == {1'b0, req_ff.address}) begin
               found_in = 1'b1; best_in = idx_ff; hold_in = rd;
            end
            if (idx_ff + ONE < count_ff && !(req_ff.operation == OP_FREE && found_in)) begin
               idx_in = idx_ff + ONE; rd_idx = idx_ff + ONE; state_in = S_SRD;
            end else begin
               state_in = S_ADEC;
            end
         end
         S_ADEC: begin
            rsp_in.payload_offset = '0;
            if (req_ff.operation == OP_ALLOC) begin
               if (req_ff.request_size == '0 || !found_ff) begin
                  rsp_in.status = ST_ALLOC_ERR; state_in = S_IDLE; rv_in = 1'b1;
               end else if (diff_ff >= HDR + SIZE_W'(8) && count_ff < MAXC) begin
                  idx_in = count_ff; size_in = rsize[SIZE_W-1:0];
                  rd_idx = count_ff - ONE; state_in = S_URD;
                  if (count_ff == best_ff + ONE) state_in = S_AFIN;
               end else begin
                  size_in = hold_ff.size; state_in = S_AFIN;
               end
            end else begin
               if (!found_ff || hold_ff.free) begin
                  rsp_in.status = ST_BAD_FREE; rsp_in.used_bytes = used_ff;
                  rsp_in.peak_bytes = peak_ff; state_in = S_IDLE; rv_in = 1'b1;
               end else begin
                  wr_en = 1'b1; wr_addr = best_ff[AW-1:0];
                  wr_data = hold_ff; wr_data.free = 1'b1;
                  if (best_ff == '0) seg0_ok_in = 1'b1;
                  used_in = (used_ff >= hold_ff.size + HDR) ? used_ff - hold_ff.size - HDR : '0;
                  idx_in = '0; rd_idx = '0; state_in = S_MRD;
               end
            end
            if (state_in == S_IDLE) begin
               rsp_in.used_bytes = used_ff; rsp_in.peak_bytes = peak_ff;
            end
         end
         S_URD: begin // shift entry idx-1 up to idx
            rd_idx = idx_ff - ONE;
            state_in = S_UWR;
         end
         S_UWR: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd;
            if (idx_ff - ONE == best_ff + ONE) begin
               state_in = S_AFIN;
            end else begin
               idx_in = idx_ff - ONE; rd_idx = idx_ff - ONE - ONE; state_in = S_URD;
            end
         end
         S_AFIN: begin
            wr_en = 1'b1; wr_addr = best_ff[AW-1:0];
            wr_data.start = hold_ff.start; wr_data.size = size_ff; wr_data.free = 1'b0;
            if (best_ff == '0) seg0_ok_in = 1'b1;
            if (size_ff != hold_ff.size) begin
               // split remainder goes in on the next cycle via S_DWR path
               hold_in.start = hold_ff.start + ADDR_W'(HEADER_BYTES) + size_ff[ADDR_W-1:0];
               hold_in.size = diff_ff - HDR; hold_in.free = 1'b1;
               count_in = count_ff + ONE;
               idx_in = best_ff + ONE;
               state_in = S_DWR;
            end else begin
               state_in = S_IDLE; rv_in = 1'b1;
            end
            used_in = used_ff + size_ff + HDR;
            peak_in = (used_in > peak_ff) ? used_in : peak_ff;
            rsp_in.status = ST_OK;
            rsp_in.payload_offset = hold_ff.start + ADDR_W'(HEADER_BYTES);
            rsp_in.used_bytes = used_in; rsp_in.peak_bytes = peak_in;
         end
         S_DWR: begin
            if (req_ff.operation == OP_ALLOC) begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = hold_ff;
               state_in = S_IDLE; rv_in = 1'b1;
            end else begin
               // merge: pull entry idx+1 down into idx
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd;
               if (idx_ff + ONE + ONE < count_ff) begin
                  idx_in = idx_ff + ONE; rd_idx = idx_ff + ONE + ONE; state_in = S_DRD;
               end else begin
                  count_in = count_ff - ONE;
                  idx_in = best_ff + ONE; rd_idx = best_ff + ONE; state_in = S_MRD;
               end
            end
         end
         S_DRD: begin
            rd_idx = idx_ff + ONE;
            state_in = S_DWR;
         end
         S_MRD: begin
            state_in = S_MCHK;
         end
         S_MCHK: begin
            // best_ff tracks left entry; hold_ff its data once read
            if (!found_ff) begin
               // rd is left entry i
               hold_in = rd; found_in = 1'b1; best_in = idx_ff;
               if (idx_ff + ONE < count_ff) begin
                  idx_in = idx_ff + ONE; rd_idx = idx_ff + ONE; state_in = S_MRD;
               end else begin
                  state_in = S_IDLE; rv_in = 1'b1;
               end
            end else if (hold_ff.free && rd.free) begin
               hold_in.size = hold_ff.size + rd.size + HDR;
               wr_en = 1'b1; wr_addr = best_ff[AW-1:0];
               wr_data = hold_ff; wr_data.size = hold_ff.size + rd.size + HDR;
               if (best_ff == '0) seg0_ok_in = 1'b1;
               if (idx_ff + ONE < count_ff) begin
                  idx_in = idx_ff; rd_idx = idx_ff + ONE; state_in = S_DRD;
               end else begin
                  count_in = count_ff - ONE; state_in = S_IDLE; rv_in = 1'b1;
               end
            end else begin
               hold_in = rd; best_in = idx_ff;
               if (idx_ff + ONE < count_ff) begin
                  idx_in = idx_ff + ONE; rd_idx = idx_ff + ONE; state_in = S_MRD;
               end else begin
                  state_in = S_IDLE; rv_in = 1'b1;
               end
            end
            rsp_in.status = ST_OK; rsp_in.payload_offset = '0;
            rsp_in.used_bytes = used_ff; rsp_in.peak_bytes = peak_ff;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_ADEC && req_ff.operation == OP_FREE && state_in == S_MRD)
         found_in = 1'b0;
   end

   assign rd_addr = rd_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= ONE; used_ff <= '0; peak_ff <= '0;
         rv_ff <= 1'b0; seg0_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; used_ff <= used_in;
         peak_ff <= peak_in; rv_ff <= rv_in; seg0_ok_ff <= seg0_ok_in;
      end
      rd_was0_ff <= (rd_addr == '0);
      idx_ff <= idx_in; best_ff <= best_in; diff_ff <= diff_in; found_ff <= found_in;
      size_ff <= size_in; hold_ff <= hold_in; req_ff <= req_in; rsp_ff <= rsp_in;
   end

   a_peak: assert property (@(posedge clock) disable iff (reset) peak_ff >= used_ff)
      else $error("peak below used");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff >= ONE && count_ff <= MAXC) else $error("segment count out of range");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == S_IDLE) else $error("response while busy");
endmodule

[rtl/bfpa_seg_mem.sv]
// Segment table memory: one write port, one read port, registered read data.
// Depends on bfpa_pkg.
module bfpa_seg_mem #(
   parameter int DEPTH = bfpa_pkg::MAX_SEGMENTS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  bfpa_pkg::seg_type    wr_data,
   input  logic [AW-1:0]        rd_addr,
   output bfpa_pkg::seg_type    rd_data
);
   import bfpa_pkg::*;

   seg_type mem [DEPTH];
   seg_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

[test/tb_top.sv]
// Testbench for best_fit_pool_allocator: random and directed allocate/free
// transactions checked against a behavioral model of the segment table.
// Depends on bfpa_pkg and the allocator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bfpa_pkg::*;

   localparam int POOL_BYTES = POOL_BLOCKS_DEF * BLOCK_BYTES_DEF;
   localparam int HDR        = HEADER_BYTES_DEF;
   localparam int MAX_SEG    = MAX_SEGMENTS_DEF;
   localparam int N_RANDOM   = 350;
   localparam int IDLE_LIMIT = 200000;

   class alloc_scoreboard;
      int unsigned seg_start[MAX_SEG];
      int unsigned seg_size[MAX_SEG];
      bit          seg_free[MAX_SEG];
      int unsigned seg_count;
      int unsigned used_total;
      int unsigned peak_total;
      rsp_type     pending[$];
      int          errors;

      function void clear();
         seg_start[0] = 0;
         seg_size[0]  = (POOL_BYTES >= HDR) ? POOL_BYTES - HDR : 0;
         seg_free[0]  = 1;
         seg_count    = 1;
         used_total   = 0;
         peak_total   = 0;
         errors       = 0;
         pending.delete();
      endfunction

      function void merge_pairs();
         int unsigned i;
         i = 0;
         while (i + 1 < seg_count) begin
            if (seg_free[i] && seg_free[i+1]) begin
               seg_size[i] += seg_size[i+1] + HDR;
               for (int unsigned k = i + 1; k + 1 < seg_count; k++) begin
                  seg_start[k] = seg_start[k+1];
                  seg_size[k]  = seg_size[k+1];
                  seg_free[k]  = seg_free[k+1];
               end
               seg_count--;
            end else begin
               i++;
            end
         end
      endfunction

      function status_type do_alloc(int unsigned req, output int unsigned offset);
         int unsigned sz, best, best_diff, diff;
         bit found;
         offset = 0;
         found = 0;
         best = 0;
         best_diff = 0;
         if (req == 0) return ST_ALLOC_ERR;
         sz = (req + 7) & ~32'd7;
         for (int unsigned i = 0; i < seg_count; i++) begin
            if (seg_free[i] && seg_size[i] >= sz) begin
               diff = seg_size[i] - sz;
               if (!found || diff < best_diff) begin
                  found = 1;
                  best = i;
                  best_diff = diff;
               end
            end
         end
         if (!found) return ST_ALLOC_ERR;
         if (best_diff >= HDR + 8 && seg_count < MAX_SEG) begin
            for (int unsigned k = seg_count; k > best + 1; k--) begin
               seg_start[k] = seg_start[k-1];
               seg_size[k]  = seg_size[k-1];
               seg_free[k]  = seg_free[k-1];
            end
            seg_start[best+1] = seg_start[best] + HDR + sz;
            seg_size[best+1]  = best_diff - HDR;
            seg_free[best+1]  = 1;
            seg_count++;
            seg_size[best] = sz;
         end
         seg_free[best] = 0;
         used_total += seg_size[best] + HDR;
         if (used_total > peak_total) peak_total = used_total;
         offset = seg_start[best] + HDR;
         return ST_OK;
      endfunction

      function status_type do_free(int unsigned addr);
         int unsigned bytes;
         for (int unsigned i = 0; i < seg_count; i++) begin
            if (seg_start[i] + HDR == addr) begin
               if (seg_free[i]) return ST_BAD_FREE;
               seg_free[i] = 1;
               bytes = seg_size[i] + HDR;
               used_total = (used_total >= bytes) ? used_total - bytes : 0;
               merge_pairs();
               return ST_OK;
            end
         end
         return ST_BAD_FREE;
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         status_type  st;
         int unsigned off;
         off = 0;
         if (r.operation == OP_ALLOC) st = do_alloc(r.request_size, off);
         else st = do_free(r.address);
         if (st != ST_OK) off = 0;
         e.status         = st;
         e.payload_offset = off[ADDR_W-1:0];
         e.used_bytes     = used_total[SIZE_W-1:0];
         e.peak_bytes     = peak_total[SIZE_W-1:0];
         e.pool_total     = POOL_BYTES[SIZE_W-1:0];
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected transaction %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.payload_offset !== e.payload_offset) begin
            $display("%0t: offset exp %0d got %0d", $time, e.payload_offset,
                     a.payload_offset);
            errors++;
         end
         if (a.used_bytes !== e.used_bytes) begin
            $display("%0t: used exp %0d got %0d", $time, e.used_bytes, a.used_bytes);
            errors++;
         end
         if (a.peak_bytes !== e.peak_bytes) begin
            $display("%0t: peak exp %0d got %0d", $time, e.peak_bytes, a.peak_bytes);
            errors++;
         end
         if (a.pool_total !== e.pool_total) begin
            $display("%0t: total exp %0d got %0d", $time, e.pool_total, a.pool_total);
            errors++;
         end
      endfunction

      // offsets currently granted, for well-formed frees
      function int unsigned pick_live(output bit ok);
         int unsigned idx[$];
         for (int unsigned i = 0; i < seg_count; i++)
            if (!seg_free[i]) idx.push_back(i);
         ok = idx.size() != 0;
         if (!ok) return 0;
         return seg_start[idx[$urandom_range(idx.size()-1)]] + HDR;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   alloc_scoreboard pool_sb;
   bit              hold_rsp;
   bit              stim_done;
   int              idle_cycles;

   best_fit_pool_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic send(input logic op, input int unsigned sz, input int unsigned addr);
      req_type r;
      r.operation    = op;
      r.request_size = sz[SIZE_W-1:0];
      r.address      = addr[ADDR_W-1:0];
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      pool_sb.note_request(r);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_gap();
      int unsigned g;
      if ($urandom_range(3) == 0) begin
         g = $urandom_range(1, 20);
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      while (pool_sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic random_item();
      int unsigned sel, a;
      bit ok;
      sel = $urandom_range(99);
      if (sel < 45) begin
         if ($urandom_range(7) == 0) a = $urandom_range(8191);
         else if ($urandom_range(3) == 0) a = $urandom_range(1, 600);
         else a = $urandom_range(1, 96);
         send(OP_ALLOC, a, $urandom_range(4095));
      end else if (sel < 85) begin
         a = pool_sb.pick_live(ok);
         if (!ok) a = $urandom_range(4095);
         send(OP_FREE, $urandom_range(8191), a);
      end else if (sel < 93) begin
         send(OP_FREE, $urandom_range(8191), $urandom_range(4095));
      end else begin
         send(OP_ALLOC, 0, $urandom_range(4095));
      end
   endtask

   // receiver: stall pattern plus a long hold when requested
   initial begin
      int unsigned phase;
      rsp_ready = 1'b0;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_rsp) rsp_ready <= 1'b0;
         else if (phase % 64 < 20) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(2) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) pool_sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned a;
      bit ok;
      pool_sb = new();
      pool_sb.clear();
      idle_cycles = 0;
      hold_rsp  = 0;
      stim_done = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send(OP_ALLOC, 0, 0);
      send(OP_ALLOC, 8191, 4095);
      send(OP_ALLOC, 1, 0);
      send(OP_ALLOC, 8, 0);
      send(OP_ALLOC, 9, 0);
      send(OP_ALLOC, 4084, 0);
      send(OP_FREE, 0, 12);
      send(OP_FREE, 0, 12);
      send(OP_FREE, 0, 0);
      send(OP_FREE, 8191, 4095);
      send(OP_ALLOC, 16, 0);
      send(OP_ALLOC, 24, 0);
      send(OP_ALLOC, 16, 0);
      send(OP_FREE, 0, 12);
      send(OP_FREE, 0, 76);
      send(OP_ALLOC, 20, 0);
      send(OP_ALLOC, 4096, 0);
      send(OP_FREE, 0, 40);
      send(OP_ALLOC, 4000, 0);
      send(OP_ALLOC, 4084, 0);
      drain();

      // long receiver hold while requests keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (2000) @(negedge clock);
            hold_rsp = 0;
         end
         repeat (30) random_item();
      join

      for (int i = 0; i < N_RANDOM; i++) begin
         random_item();
         send_gap();
         if (i % 150 == 149) drain();
         // burst of tiny allocations
         if (i == 200) begin
            repeat (40) send(OP_ALLOC, $urandom_range(1, 8), 0);
         end
      end
      // release everything that is still granted
      a = pool_sb.pick_live(ok);
      while (ok) begin
         send(OP_FREE, 0, a);
         a = pool_sb.pick_live(ok);
      end
      drain();
      repeat (50) @(posedge clock);
      if (pool_sb.errors == 0 && pool_sb.pending.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

[files.f]
rtl/bfpa_pkg.sv
rtl/bfpa_seg_mem.sv
rtl/best_fit_pool_allocator.sv
test/tb_top.sv
